/* hw/rtl/lzss_pkg.sv */
package lzss_pkg;

  // Window geometry.
  localparam int unsigned WIN_DEPTH = 4096;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);

  // The write position that every block starts from.
  localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(4078);

  // Number of length-header bytes skipped at the head of a block.
  localparam logic [2:0] HEADER_BYTES = 3'd4;

  // A reference copies its length nibble plus this many bytes.
  localparam int unsigned MIN_RUN = 3;

  // Width of the remaining-bytes counter of a copy run (length minus one).
  localparam int unsigned RUN_W = 5;

  // Number of tokens governed by one flag byte.
  localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic blk_clear;  // restart the window at the head of a block
    logic hold_low;   // keep the first byte of a reference
    logic load_lit;   // capture a literal byte
    logic load_ref;   // set up a copy run from the second reference byte
    logic rd_issue;   // read the window at the copy address
    logic emit_lit;   // store and send the captured literal
    logic emit_copy;  // store and send the byte just read
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // the output register can take a byte this cycle
    logic copy_done;  // the byte being copied is the last of its run
  } sts_t;

endpackage

/* hw/rtl/lzss_in_if.sv */
interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

/* hw/rtl/lzss_out_if.sv */
interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

/* hw/rtl/lzss_ctrl.sv */
module lzss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic                block_start_i,
  output logic                in_ready_o,
  input  lzss_pkg::sts_t      sts_i,
  output lzss_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_RD,
    ST_CP
  } state_e;

  state_e      state_q, state_d;
  logic [2:0]  header_left_q, header_left_d;
  logic [7:0]  flag_bits_q, flag_bits_d;
  logic [3:0]  flags_left_q, flags_left_d;
  logic        awaiting_q, awaiting_d;

  // Parser values as seen by the current item, after a block start.
  logic [2:0]  hl_eff;
  logic [7:0]  fb_eff;
  logic [3:0]  fl_eff;
  logic        aw_eff;

  always_comb begin
    hl_eff = block_start_i ? lzss_pkg::HEADER_BYTES : header_left_q;
    fb_eff = block_start_i ? 8'h00 : flag_bits_q;
    fl_eff = block_start_i ? 4'd0 : flags_left_q;
    aw_eff = block_start_i ? 1'b0 : awaiting_q;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Token parser and copy sequencing.
  always_comb begin
    state_d       = state_q;
    header_left_d = header_left_q;
    flag_bits_d   = flag_bits_q;
    flags_left_d  = flags_left_q;
    awaiting_d    = awaiting_q;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          header_left_d   = hl_eff;
          flag_bits_d     = fb_eff;
          flags_left_d    = fl_eff;
          awaiting_d      = aw_eff;
          cmd_o.blk_clear = block_start_i;
          if (hl_eff != 3'd0) begin
            header_left_d = hl_eff - 3'd1;
          end else if (aw_eff) begin
            awaiting_d     = 1'b0;
            cmd_o.load_ref = 1'b1;
            flag_bits_d    = fb_eff >> 1;
            flags_left_d   = (fl_eff != 4'd0) ? fl_eff - 4'd1 : fl_eff;
            state_d        = ST_RD;
          end else if (fl_eff == 4'd0) begin
            flag_bits_d  = data_byte_i;
            flags_left_d = lzss_pkg::FLAGS_PER_BYTE;
          end else if (fb_eff[0]) begin
            cmd_o.load_lit = 1'b1;
            flag_bits_d    = fb_eff >> 1;
            flags_left_d   = fl_eff - 4'd1;
            state_d        = ST_LIT;
          end else begin
            cmd_o.hold_low = 1'b1;
            awaiting_d     = 1'b1;
          end
        end
      end
      ST_LIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_lit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_CP;
      end
      ST_CP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_copy = 1'b1;
          state_d         = sts_i.copy_done ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      header_left_q <= lzss_pkg::HEADER_BYTES;
      flag_bits_q   <= 8'h00;
      flags_left_q  <= 4'd0;
      awaiting_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      header_left_q <= header_left_d;
      flag_bits_q   <= flag_bits_d;
      flags_left_q  <= flags_left_d;
      awaiting_q    <= awaiting_d;
    end
  end

`ifndef SYNTHESIS
  // A flag byte never governs more than eight tokens.
  a_flags_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_left_q <= lzss_pkg::FLAGS_PER_BYTE)
    else $error("flag counter out of range");

  // The last byte of a run returns the parser to taking items.
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CP && sts_i.out_free && sts_i.copy_done) |=> state_q == ST_IDLE)
    else $error("copy run did not end");

  // A pending reference half always has a flag to consume.
  a_await_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> flags_left_q != 4'd0)
    else $error("reference pending without a flag");
`endif

endmodule

/* hw/rtl/lzss_dpath.sv */
module lzss_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  lzss_pkg::cmd_t      cmd_i,
  output lzss_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o
);

  localparam int unsigned AW = lzss_pkg::WIN_AW;

  // History window.
  logic [7:0] win_mem [lzss_pkg::WIN_DEPTH];
  logic [7:0] rd_data_q;

  logic [AW-1:0]               wr_pos_q;
  logic [AW:0]                 fill_q;
  logic [7:0]                  held_low_q;
  logic [7:0]                  lit_q;
  logic [AW-1:0]               copy_addr_q;
  logic [lzss_pkg::RUN_W-1:0]  copy_left_q;
  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic                        run_last_q;

  logic          wr_en;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_offset;
  logic          rd_hit;
  logic [7:0]    copy_byte;

  // An entry counts as written when it lies within the bytes stored since the
  // block began; all others read as zero, which stands in for clearing.
  assign rd_offset = copy_addr_q - lzss_pkg::START_POS;
  assign rd_hit    = {1'b0, rd_offset} < fill_q;
  assign copy_byte = rd_hit ? rd_data_q : 8'h00;

  assign wr_en   = cmd_i.emit_lit | cmd_i.emit_copy;
  assign wr_data = cmd_i.emit_lit ? lit_q : copy_byte;

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.copy_done = (copy_left_q == '0);

  // Window write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[wr_pos_q] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= win_mem[copy_addr_q];
    end
  end

  // Write position and count of bytes stored in this block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= lzss_pkg::START_POS;
      fill_q   <= '0;
    end else if (cmd_i.blk_clear) begin
      wr_pos_q <= lzss_pkg::START_POS;
      fill_q   <= '0;
    end else if (wr_en) begin
      wr_pos_q <= wr_pos_q + 1'b1;
      if (fill_q != (AW+1)'(lzss_pkg::WIN_DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Token payload and copy run registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_low) begin
      held_low_q <= data_byte_i;
    end
    if (cmd_i.load_lit) begin
      lit_q <= data_byte_i;
    end
    if (cmd_i.load_ref) begin
      copy_addr_q <= {data_byte_i[7:4], held_low_q};
      copy_left_q <= lzss_pkg::RUN_W'(data_byte_i[3:0]) + lzss_pkg::RUN_W'(lzss_pkg::MIN_RUN - 1);
    end else if (cmd_i.emit_copy) begin
      copy_addr_q <= copy_addr_q + 1'b1;
      copy_left_q <= copy_left_q - 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_byte_q <= wr_data;
      run_last_q <= cmd_i.emit_lit | sts_o.copy_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

`ifndef SYNTHESIS
  // A byte is only stored and sent when the output register has room.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> sts_o.out_free)
    else $error("emit into a full output register");

  // A block start puts the write position back at its start.
  a_blk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.blk_clear |=> (wr_pos_q == lzss_pkg::START_POS && fill_q == '0))
    else $error("block start did not restart the window");

  // The stored-byte count never passes the window size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (AW+1)'(lzss_pkg::WIN_DEPTH))
    else $error("fill count out of range");
`endif

endmodule

/* hw/rtl/lzss_decompressor_unit.sv */
// LZSS decoder with a 4096-byte history window and 12-bit absolute offsets.
// Each input item is one compressed byte; block_start on the first byte of a
// block restarts the parser, skips four header bytes and makes the window read
// as all zero with the write position at 4078, at once and without stalling.
// Header, flag and first reference bytes are taken as they come and give no
// output. A literal is captured, then stored and sent as one output item when
// the output register has room. The second byte of a reference gives a run of
// L = 3..18 output items: each copied byte takes a registered window read, then
// is stored back as it loads the output register, so overlapping copies see
// their own bytes. run_last marks the final output item of each input item. The
// output register lets a waiting byte sit while header and flag bytes flow on.
module lzss_decompressor_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  lzss_in_if.sink       in_i,
  lzss_out_if.source    out_o
);

  lzss_pkg::cmd_t cmd;
  lzss_pkg::sts_t sts;
  logic           in_ready;

  lzss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .data_byte_i   (in_i.data_byte),
    .block_start_i (in_i.block_start),
    .in_ready_o    (in_ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lzss_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last)
  );

  assign in_i.ready = in_ready;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned HOLD_OFF_LEN  = 400;
  localparam int unsigned RANDOM_TOKENS = 330;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY4,
    RX_MOSTLY
  } rx_mode_e;

  // One decompressed byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_item_t;

  logic clk_i;
  logic rst_ni;

  lzss_in_if  in_if ();
  lzss_out_if out_if ();

  lzss_decompressor_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Decoder state kept by the testbench.
  logic [7:0]                 win_mem [lzss_pkg::WIN_DEPTH];
  logic [lzss_pkg::WIN_AW-1:0] wr_pos;
  logic [7:0]                 flag_sr;
  logic [3:0]                 flags_cnt;
  logic [2:0]                 hdr_cnt;
  logic [7:0]                 low_hold;
  logic                       await_hi;

  out_item_t   expected_bytes [$];
  out_item_t   want;
  int unsigned err_cnt;
  int unsigned token_cnt;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned hold_off_cycles;
  bit          steady_send;

  // Clock.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Restart the decoder state as a block start does.
  function automatic void start_block();
    foreach (win_mem[i]) win_mem[i] = '0;
    wr_pos    = lzss_pkg::START_POS;
    flag_sr   = '0;
    flags_cnt = '0;
    hdr_cnt   = lzss_pkg::HEADER_BYTES;
    low_hold  = '0;
    await_hi  = 1'b0;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    win_mem[wr_pos] = b;
    wr_pos = wr_pos + 1'b1;
  endfunction

  function automatic void shift_flag();
    flag_sr = flag_sr >> 1;
    if (flags_cnt != 0) flags_cnt = flags_cnt - 1'b1;
  endfunction

  // Work out the bytes that one accepted compressed byte produces.
  function automatic void decode_byte(input logic [7:0] b, input logic bs);
    logic [lzss_pkg::WIN_AW-1:0] src;
    int unsigned                 run_len;
    logic [7:0]                  v;
    out_item_t                   item;
    if (bs) start_block();
    if (hdr_cnt != 0) begin
      hdr_cnt = hdr_cnt - 1'b1;
      return;
    end
    token_cnt++;
    if (await_hi) begin
      // Second reference byte: copy the run, writing each byte back as it goes.
      await_hi = 1'b0;
      src = {b[7:4], low_hold};
      run_len = int'(b[3:0]) + lzss_pkg::MIN_RUN;
      for (int k = 0; k < run_len; k++) begin
        v = win_mem[src];
        store_byte(v);
        item.data = v;
        item.last = (k == run_len - 1);
        expected_bytes = {expected_bytes, item};
        src = src + 1'b1;
      end
      shift_flag();
    end else if (flags_cnt == 0) begin
      flag_sr   = b;
      flags_cnt = lzss_pkg::FLAGS_PER_BYTE;
    end else if (flag_sr[0]) begin
      store_byte(b);
      item.data = b;
      item.last = 1'b1;
      expected_bytes = {expected_bytes, item};
      shift_flag();
    end else begin
      low_hold = b;
      await_hi = 1'b1;
    end
  endfunction

  // Offer one item in random bursts and predict its output once it is taken.
  task automatic send_byte(input logic [7:0] b, input logic bs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.block_start <= bs;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(b, bs);
  endtask

  task automatic send_header(input logic bs);
    send_byte(8'($urandom_range(0, 255)), bs);
    repeat (int'(lzss_pkg::HEADER_BYTES) - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Send a reference aimed at a random window byte, near the block start, or at a recently written byte.
  task automatic send_reference(input logic [3:0] len_code);
    logic [lzss_pkg::WIN_AW-1:0] pos;
    case ($urandom_range(0, 2))
      0: pos = lzss_pkg::WIN_AW'($urandom_range(0, lzss_pkg::WIN_DEPTH - 1));
      1: pos = lzss_pkg::START_POS + lzss_pkg::WIN_AW'($urandom_range(0, 255));
      default: pos = wr_pos - lzss_pkg::WIN_AW'($urandom_range(1, 18));
    endcase
    send_byte(pos[7:0], 1'b0);
    send_byte({pos[11:8], len_code}, 1'b0);
  endtask

  // A well-formed block with random content, sometimes cut short.
  task automatic send_random_block();
    int unsigned groups;
    logic [7:0]  flags;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    send_header(1'b1);
    for (int g = 0; g < groups; g++) begin
      case ($urandom_range(0, 9))
        0: flags = 8'h00;
        1: flags = 8'hFF;
        default: flags = 8'($urandom_range(0, 255));
      endcase
      send_byte(flags, 1'b0);
      for (int t = 0; t < 8; t++) begin
        if ($urandom_range(0, 39) == 0) begin
          // Leave the block early, possibly inside a reference.
          if (!flags[t] && $urandom_range(0, 1) == 1)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
          return;
        end
        if (flags[t]) send_byte(8'($urandom_range(0, 255)), 1'b0);
        else send_reference(4'($urandom_range(0, 15)));
      end
    end
  endtask

  // Decoding must begin with header skipping even without a block start.
  task automatic test_decode_without_block_start();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFD, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Shortest run, starting at the byte just written, so the copy overlaps.
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // A reference cut by a new block, the window clear, and the longest run.
  task automatic test_block_cut_and_window_clear();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // The first test wrote 0xFF here; a cleared window reads zero.
    send_byte(8'hEE, 1'b0);
    send_byte(8'hF2, 1'b0);
    // Longest run from the top of the window, wrapping to the bottom.
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Long runs while the receiver holds off, so the input must stall.
  task automatic test_output_hold_off();
    steady_send     = 1'b1;
    hold_off_cycles = HOLD_OFF_LEN;
    send_header(1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    repeat (7) send_reference(4'hF);
    steady_send = 1'b0;
  endtask

  // Mostly well-formed blocks with some stray bytes in between.
  task automatic test_random_blocks();
    token_cnt = 0;
    while (token_cnt < RANDOM_TOKENS) begin
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      send_random_block();
    end
  endtask

  // Stimulus and end of run.
  initial begin
    err_cnt         = 0;
    token_cnt       = 0;
    burst_left      = 0;
    hold_off_cycles = 0;
    steady_send     = 1'b0;
    start_block();
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.block_start <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decode_without_block_start();
    test_block_cut_and_window_clear();
    test_output_hold_off();
    test_random_blocks();

    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: segments of different stall patterns, and one long hold-off on request.
  initial begin
    rx_mode_e    mode;
    int unsigned seg;
    logic        rdy;
    forever begin
      if (hold_off_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      seg  = $urandom_range(20, 120);
      for (int i = 0; i < seg && hold_off_cycles == 0; i++) begin
        case (mode)
          RX_ALWAYS: rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_EVERY4: rdy = (i % 4 == 0);
          default:   rdy = ($urandom_range(0, 9) != 0);
        endcase
        out_if.ready <= rdy;
        @(posedge clk_i);
      end
    end
  end

  // Compare each output item with the oldest expected byte.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected output, actual out_byte %02h run_last %0b",
                 $time, out_if.out_byte, out_if.run_last);
      end else begin
        want = expected_bytes.pop_front();
        if (out_if.out_byte !== want.data) begin
          err_cnt++;
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, want.data, out_if.out_byte);
        end
        if (out_if.run_last !== want.last) begin
          err_cnt++;
          $display("%0t: run_last mismatch, expected %0b, actual %0b",
                   $time, want.last, out_if.run_last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* lzss_decompressor_unit.f */
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_in_if.sv
hw/rtl/lzss_out_if.sv
hw/rtl/lzss_ctrl.sv
hw/rtl/lzss_dpath.sv
hw/rtl/lzss_decompressor_unit.sv
tb/sv/tb_top.sv
